### design/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// No dependencies; imported by stq_cell and sorted_timer_queue.
package stq_pkg;

  localparam int STQ_DEPTH = 16;

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_REMOVE   = 2'd1;
  localparam logic [1:0] MODE_CHECK    = 2'd2;
  localparam logic [1:0] MODE_CLEAR    = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [31:0] ID_FIRST = 32'd1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_SHIFT,
    OP_CLEAR
  } stq_op_t;

  // broadcast to every cell
  typedef struct packed {
    stq_op_t     op;
    logic [63:0] key;
    logic [31:0] new_id;
    logic        match_en;
    logic [31:0] target_id;
  } stq_ctl_t;

  // contents of one cell, handed to its neighbors
  typedef struct packed {
    logic        valid;
    logic [63:0] trig;
    logic [31:0] id;
  } stq_link_t;

endpackage

### design/stq_cell.sv
// One slot of the sorted timer chain: holds a trigger time and id.
// Depends on stq_pkg.
module stq_cell import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  stq_ctl_t  ctl,
  input  stq_link_t left,
  input  stq_link_t right,
  input  logic      stay_in,
  input  logic      rm_in,
  output stq_link_t own,
  output logic      stay_out,
  output logic      rm_out
);

  logic        valid_r, valid_nxt;
  logic [63:0] trig_r, trig_nxt;
  logic [31:0] id_r, id_nxt;
  logic        hit;

  assign own      = '{valid: valid_r, trig: trig_r, id: id_r};
  assign hit      = ctl.match_en && valid_r && (id_r == ctl.target_id);
  assign stay_out = valid_r && (trig_r <= ctl.key);
  assign rm_out   = rm_in | hit;

  always_comb begin
    valid_nxt = valid_r;
    trig_nxt  = trig_r;
    id_nxt    = id_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (!stay_out) begin
          if (stay_in) begin
            valid_nxt = 1'b1;
            trig_nxt  = ctl.key;
            id_nxt    = ctl.new_id;
          end else begin
            valid_nxt = left.valid;
            trig_nxt  = left.trig;
            id_nxt    = left.id;
          end
        end
      end
      OP_SHIFT: begin
        if (rm_out) begin
          valid_nxt = right.valid;
          trig_nxt  = right.trig;
          id_nxt    = right.id;
        end
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    trig_r <= trig_nxt;
    id_r   <= id_nxt;
  end

endmodule

### design/sorted_timer_queue.sv
// Sorted timer queue top level: request sequencing, id counter, result stage.
// Depends on stq_pkg and stq_cell.
//
// A request is taken into the request registers (the trigger time now +
// delay is formed there), then applied to the chain of cells while its
// result goes to the pending register, and moves on to the output register,
// with the head delay taken from the updated head cell, once the output side
// is free. No new request is accepted while one is applied to the cell
// chain or while a result waits in the pending register behind a stalled
// output; the result register frees the input side while a result waits to
// be taken. Each cell compares its trigger time and id against the broadcast
// request and takes its own, its left or its right neighbor's contents, so
// inserts and removes finish in a single update of the chain at any depth.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int QUEUE_DEPTH = STQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_now,
  input  logic [63:0] in_delay,
  input  logic [31:0] in_target_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_id,
  output logic        out_fired,
  output logic        out_timeout_load,
  output logic [63:0] out_timeout_delay
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [63:0] now_r, now_nxt;
  logic [63:0] trig_r, trig_nxt;
  logic [31:0] target_r, target_nxt;
  logic [31:0] id_ctr_r, id_ctr_nxt;

  logic        pend_r, pend_nxt;
  logic [1:0]  p_status_r, p_status_nxt;
  logic [31:0] p_rid_r, p_rid_nxt;
  logic        p_fired_r, p_fired_nxt;
  logic        p_load_r, p_load_nxt;
  logic [63:0] p_now_r, p_now_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_rid_r, out_rid_nxt;
  logic        out_fired_r, out_fired_nxt;
  logic        out_load_r, out_load_nxt;
  logic [63:0] out_delay_r, out_delay_nxt;

  stq_ctl_t    ctl;
  stq_link_t   own [QUEUE_DEPTH];
  stq_link_t   rlink [QUEUE_DEPTH];
  logic        stay_w [QUEUE_DEPTH];
  logic        rm_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vbits;

  logic        in_acc, out_free, pend_load;
  logic        full, empty, due, fire;
  logic [31:0] id_new;
  logic [63:0] head_trig;
  logic [63:0] head_dly;

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    stq_link_t llink;
    logic      stay_in, rm_in;

    if (i == 0) begin : g_first
      assign llink   = '0;
      assign stay_in = 1'b1;
      assign rm_in   = fire;
    end else begin : g_mid
      assign llink   = own[i-1];
      assign stay_in = stay_w[i-1];
      assign rm_in   = rm_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rlink[i] = '0;
    end else begin : g_inner
      assign rlink[i] = own[i+1];
    end

    assign vbits[i] = own[i].valid;

    stq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .left     (llink),
      .right    (rlink[i]),
      .stay_in  (stay_in),
      .rm_in    (rm_in),
      .own      (own[i]),
      .stay_out (stay_w[i]),
      .rm_out   (rm_w[i])
    );
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign pend_load = pend_r && out_free;
  assign in_stall  = (state_r != ST_IDLE) || (pend_r && !out_free);
  assign in_acc    = in_valid && !in_stall;

  assign full   = own[QUEUE_DEPTH-1].valid;
  assign empty  = !own[0].valid;
  assign due    = own[0].trig <= now_r;
  assign fire   = (state_r == ST_EXEC) && (mode_r == MODE_CHECK) && !empty && due;
  assign id_new = (id_ctr_r == '0) ? ID_FIRST : id_ctr_r;

  always_comb begin
    ctl           = '0;
    ctl.op        = OP_NONE;
    ctl.key       = trig_r;
    ctl.new_id    = id_new;
    ctl.target_id = target_r;
    if (state_r == ST_EXEC) begin
      unique case (mode_r)
        MODE_REGISTER: ctl.op = full ? OP_NONE : OP_INSERT;
        MODE_REMOVE: begin
          ctl.op       = OP_SHIFT;
          ctl.match_en = 1'b1;
        end
        MODE_CHECK:    ctl.op = fire ? OP_SHIFT : OP_NONE;
        MODE_CLEAR:    ctl.op = OP_CLEAR;
      endcase
    end
  end

  assign head_trig = own[0].trig;
  assign head_dly  = (p_load_r && (head_trig > p_now_r)) ? (head_trig - p_now_r) : 64'd0;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    now_nxt        = now_r;
    trig_nxt       = trig_r;
    target_nxt     = target_r;
    id_ctr_nxt     = id_ctr_r;
    pend_nxt       = pend_r;
    p_status_nxt   = p_status_r;
    p_rid_nxt      = p_rid_r;
    p_fired_nxt    = p_fired_r;
    p_load_nxt     = p_load_r;
    p_now_nxt      = p_now_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rid_nxt    = out_rid_r;
    out_fired_nxt  = out_fired_r;
    out_load_nxt   = out_load_r;
    out_delay_nxt  = out_delay_r;

    if (pend_load) begin
      pend_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = p_status_r;
      out_rid_nxt    = p_rid_r;
      out_fired_nxt  = p_fired_r;
      out_load_nxt   = p_load_r;
      out_delay_nxt  = head_dly;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_mode;
          now_nxt    = in_now;
          trig_nxt   = in_now + in_delay;
          target_nxt = in_target_id;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        pend_nxt     = 1'b1;
        p_status_nxt = STATUS_OK;
        p_rid_nxt    = '0;
        p_fired_nxt  = 1'b0;
        p_load_nxt   = 1'b0;
        p_now_nxt    = now_r;
        state_nxt    = ST_IDLE;
        unique case (mode_r)
          MODE_REGISTER: begin
            if (full) begin
              p_status_nxt = STATUS_FULL;
            end else begin
              p_rid_nxt  = id_new;
              p_load_nxt = !stay_w[0];
              id_ctr_nxt = (id_ctr_r == '0) ? ID_FIRST + 32'd1 : id_ctr_r + 32'd1;
            end
          end
          MODE_REMOVE: begin
            p_load_nxt = rm_w[0] && rlink[0].valid;
          end
          MODE_CHECK: begin
            if (empty) begin
              p_status_nxt = STATUS_EMPTY;
            end else if (!due) begin
              p_load_nxt = 1'b1;
            end else begin
              p_fired_nxt = 1'b1;
              p_rid_nxt   = own[0].id;
              p_load_nxt  = rlink[0].valid;
            end
          end
          MODE_CLEAR: begin
            id_ctr_nxt = ID_FIRST;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      id_ctr_r    <= ID_FIRST;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      id_ctr_r    <= id_ctr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    now_r        <= now_nxt;
    trig_r       <= trig_nxt;
    target_r     <= target_nxt;
    p_status_r   <= p_status_nxt;
    p_rid_r      <= p_rid_nxt;
    p_fired_r    <= p_fired_nxt;
    p_load_r     <= p_load_nxt;
    p_now_r      <= p_now_nxt;
    out_status_r <= out_status_nxt;
    out_rid_r    <= out_rid_nxt;
    out_fired_r  <= out_fired_nxt;
    out_load_r   <= out_load_nxt;
    out_delay_r  <= out_delay_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_rid_r;
  assign out_fired         = out_fired_r;
  assign out_timeout_load  = out_load_r;
  assign out_timeout_delay = out_delay_r;

  // occupied cells form a contiguous run from the head
  a_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    (vbits & (vbits + 1'b1)) == '0)
    else $error("cell valid bits not contiguous");

  a_exec_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> in_stall ##1 pend_r)
    else $error("update cycle did not leave a pending result");

  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_SHIFT && rm_w[QUEUE_DEPTH-1])
      |=> $countones(vbits) == $past($countones(vbits)) - 1)
    else $error("removal did not drop exactly one entry");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_INSERT) |=> $countones(vbits) == $past($countones(vbits)) + 1)
    else $error("insert did not add exactly one entry");

  a_fired_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> (out_rid_r != '0 && out_status_r == STATUS_OK))
    else $error("fired item carries a zero id or bad status");

endmodule
